// ===== hw/rtl/rtcu_pkg.sv =====
// Package for the RTC field to Unix time converter.
// Holds shared constants, the days-before-month table, a BCD helper and stage types.
// Depends on nothing; every other file in hw/rtl imports it.
package rtcu_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index as decoded from paddr[2].
    localparam logic REG_BINARY_FORMAT = 1'b0;
    localparam logic REG_HOURS_24      = 1'b1;

    localparam int DAYS_W = 17;
    localparam int HMS_W  = 20;

    // The epoch offset of 10957 days, less the one day for the day-of-month origin.
    localparam logic [DAYS_W-1:0] EPOCH_DAYS_M1 = 17'd10956;
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 17'd365;
    localparam logic [DAYS_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [HMS_W-1:0]  SECS_PER_HOUR = 20'd3600;
    localparam logic [HMS_W-1:0]  SECS_PER_MIN  = 20'd60;

    localparam logic [7:0] HOUR_NOON = 8'd12;
    localparam logic [7:0] HOUR_PM   = 8'd12;

    typedef struct packed {
        logic [7:0] sec;
        logic [7:0] min;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] year;
        logic [3:0] month_idx;
        logic       month_err;
    } rtcu_fields_t;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [HMS_W-1:0]  hms;
        logic              month_err;
    } rtcu_days_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        begin
            case (idx)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd59;
                4'd3:    d = 9'd90;
                4'd4:    d = 9'd120;
                4'd5:    d = 9'd151;
                4'd6:    d = 9'd181;
                4'd7:    d = 9'd212;
                4'd8:    d = 9'd243;
                4'd9:    d = 9'd273;
                4'd10:   d = 9'd304;
                4'd11:   d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

    // Low nibble plus ten times the high nibble, with no digit check.
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] hi;
        begin
            hi = {4'b0, v[7:4]};
            return {4'b0, v[3:0]} + (hi << 3) + (hi << 1);
        end
    endfunction

endpackage

// ===== hw/rtl/rtcu_decode.sv =====
// First pipeline stage: BCD to binary, 12-hour fixup and month range check.
// Depends on rtcu_pkg for the field struct and the BCD helper.
module rtcu_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  binary_format,
    input  logic                  hours_24,
    input  logic [7:0]            seconds_raw,
    input  logic [7:0]            minutes_raw,
    input  logic [7:0]            hours_raw,
    input  logic [7:0]            day_raw,
    input  logic [7:0]            month_raw,
    input  logic [7:0]            year_raw,
    output logic                  out_valid,
    output rtcu_pkg::rtcu_fields_t out_fields
);
    import rtcu_pkg::*;

    logic         valid_reg;
    rtcu_fields_t fields_reg;
    rtcu_fields_t fields_next;
    logic [7:0]   hour_bin;
    logic [7:0]   hour_low;
    logic [7:0]   month_bin;
    logic [7:0]   bcd_hour_tens;

    always_comb
    begin
        bcd_hour_tens = {5'b0, hours_raw[6:4]};
        if (binary_format)
        begin
            fields_next.sec  = seconds_raw;
            fields_next.min  = minutes_raw;
            fields_next.day  = day_raw;
            fields_next.year = year_raw;
            month_bin        = month_raw;
            hour_bin         = hours_raw;
        end
        else
        begin
            fields_next.sec  = bcd_to_bin(seconds_raw);
            fields_next.min  = bcd_to_bin(minutes_raw);
            fields_next.day  = bcd_to_bin(day_raw);
            fields_next.year = bcd_to_bin(year_raw);
            month_bin        = bcd_to_bin(month_raw);
            // Bit 7 of the hour is carried through as its own weight.
            hour_bin = {4'b0, hours_raw[3:0]} + (bcd_hour_tens << 3) + (bcd_hour_tens << 1)
                       + {hours_raw[7], 7'b0};
        end

        hour_low = {1'b0, hour_bin[6:0]};
        if (hours_24)
        begin
            fields_next.hour = hour_bin;
        end
        else
        begin
            if (hour_low == HOUR_NOON)
            begin
                hour_low = 8'd0;
            end
            fields_next.hour = hour_bin[7] ? hour_low + HOUR_PM : hour_low;
        end

        fields_next.month_err = (month_bin == 8'd0) || (month_bin > 8'd12);
        fields_next.month_idx = fields_next.month_err ? 4'd0 : month_bin[3:0] - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            fields_reg <= fields_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_fields = fields_reg;

endmodule

// ===== hw/rtl/rtcu_calc.sv =====
// Second and third pipeline stages: day count and time of day, then the day multiply.
// Depends on rtcu_pkg for the stage structs, constants and the month table.
module rtcu_calc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rtcu_pkg::rtcu_fields_t in_fields,
    output logic                  out_valid,
    output logic [31:0]           day_secs,
    output logic [rtcu_pkg::HMS_W-1:0] hms,
    output logic                  month_err
);
    import rtcu_pkg::*;

    logic              s2_valid_reg;
    rtcu_days_t        s2_reg;
    rtcu_days_t        s2_next;
    logic              s3_valid_reg;
    logic [31:0]       s3_prod_reg;
    logic [HMS_W-1:0]  s3_hms_reg;
    logic              s3_err_reg;
    logic [8:0]        leap_count;
    logic              leap_passed;
    logic [2*DAYS_W-1:0] prod_full;

    always_comb
    begin
        leap_count  = ({1'b0, in_fields.year} + 9'd3) >> 2;
        // The leap day counts only once February is over.
        leap_passed = (in_fields.year[1:0] == 2'b00) && (in_fields.month_idx > 4'd1);
        s2_next.days = {9'b0, in_fields.year} * DAYS_PER_YEAR
                       + {8'b0, leap_count}
                       + {8'b0, days_before_month(in_fields.month_idx)}
                       + {9'b0, in_fields.day}
                       + {16'b0, leap_passed}
                       + EPOCH_DAYS_M1;
        s2_next.hms = {12'b0, in_fields.sec}
                      + {12'b0, in_fields.min} * SECS_PER_MIN
                      + {12'b0, in_fields.hour} * SECS_PER_HOUR;
        s2_next.month_err = in_fields.month_err;
        prod_full = s2_reg.days * SECS_PER_DAY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s2_reg <= s2_next;
        end
        if (s2_valid_reg)
        begin
            s3_prod_reg <= prod_full[31:0];
            s3_hms_reg  <= s2_reg.hms;
            s3_err_reg  <= s2_reg.month_err;
        end
    end

    assign out_valid = s3_valid_reg;
    assign day_secs  = s3_prod_reg;
    assign hms       = s3_hms_reg;
    assign month_err = s3_err_reg;

endmodule

// ===== hw/rtl/rtc_fields_to_unix_time.sv =====
// Top level of the RTC field to Unix time converter: APB registers and the final add stage.
// Depends on rtcu_pkg, rtcu_decode and rtcu_calc.
//
//  Channel   Handshake             Payload
//  --------  --------------------  ----------------------------------------------
//  command   start, busy (low)     seconds/minutes/hours/day/month/year _raw
//  result    done (one cycle)      unix_seconds, month_error
//  config    psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// Four register stages: decode, day count, day multiply, final add. Each
// transaction passes through them in that order, and a new one may enter
// every cycle since busy never rises. The receiver cannot stall.
// Reset clears the stage valid bits and sets binary_format to 0, hours_24 to 1.
module rtc_fields_to_unix_time (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [7:0]                      seconds_raw,
    input  logic [7:0]                      minutes_raw,
    input  logic [7:0]                      hours_raw,
    input  logic [7:0]                      day_raw,
    input  logic [7:0]                      month_raw,
    input  logic [7:0]                      year_raw,
    output logic                            done,
    output logic [31:0]                     unix_seconds,
    output logic                            month_error,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtcu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rtcu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rtcu_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import rtcu_pkg::*;

    logic             binary_format_reg;
    logic             hours_24_reg;
    logic             cfg_write;
    logic             accept;
    logic             s1_valid;
    rtcu_fields_t     s1_fields;
    logic             s3_valid;
    logic [31:0]      s3_day_secs;
    logic [HMS_W-1:0] s3_hms;
    logic             s3_err;
    logic             done_reg;
    logic [31:0]      unix_reg;
    logic             err_reg;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_format_reg <= 1'b0;
            hours_24_reg      <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_BINARY_FORMAT: binary_format_reg <= pwdata[0];
                REG_HOURS_24:      hours_24_reg      <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BINARY_FORMAT: prdata = {31'b0, binary_format_reg};
            REG_HOURS_24:      prdata = {31'b0, hours_24_reg};
            default:           prdata = '0;
        endcase
    end

    rtcu_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .binary_format (binary_format_reg),
        .hours_24      (hours_24_reg),
        .seconds_raw   (seconds_raw),
        .minutes_raw   (minutes_raw),
        .hours_raw     (hours_raw),
        .day_raw       (day_raw),
        .month_raw     (month_raw),
        .year_raw      (year_raw),
        .out_valid     (s1_valid),
        .out_fields    (s1_fields)
    );

    rtcu_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_fields (s1_fields),
        .out_valid (s3_valid),
        .day_secs  (s3_day_secs),
        .hms       (s3_hms),
        .month_err (s3_err)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid)
        begin
            unix_reg <= s3_day_secs + {{(32-HMS_W){1'b0}}, s3_hms};
            err_reg  <= s3_err;
        end
    end

    assign done         = done_reg;
    assign unix_seconds = unix_reg;
    assign month_error  = err_reg;

    // Every accepted transaction comes out as a done strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted transaction did not complete after four cycles");

    // No result appears without a matching accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result strobe without a matching transaction");

    // The configuration must not change under a transaction in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid || s3_valid) |-> $stable(binary_format_reg) && $stable(hours_24_reg))
        else $error("configuration changed while a transaction was in flight");

endmodule
